FILE: rtl/krbp_pkg.sv
// Shared constants for the key record bit packer.
`default_nettype none

package krbp_pkg;

	localparam int KRBP_MAX_OFFSET_WIDTH = 31;

	localparam int W_FIELD_BITS = 6;
	localparam int OFFSET_BITS  = 31;
	localparam int BOFF_BITS    = 3;
	localparam int BLEN_BITS    = 8;
	localparam int DATA_BITS    = 8;
	localparam int TAIL_BITS    = BOFF_BITS + BLEN_BITS;
	localparam int HDR_FIXED_BITS = W_FIELD_BITS + TAIL_BITS;

	localparam int TDATA_BITS = 56;
	localparam int OFFSET_LSB = 0;
	localparam int BOFF_LSB   = OFFSET_LSB + OFFSET_BITS;
	localparam int BLEN_LSB   = BOFF_LSB + BOFF_BITS;
	localparam int DATA_LSB   = BLEN_LSB + BLEN_BITS;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	localparam int FIFO_DEPTH = 4;

endpackage

`default_nettype wire

FILE: rtl/krbp_front.sv
// Front end: accepts requests, tracks the open record and builds bit-run entries.
`default_nettype none

module krbp_front
	import krbp_pkg::*;
#(
	parameter int MAX_OFFSET_WIDTH = KRBP_MAX_OFFSET_WIDTH,
	localparam int HB    = HDR_FIXED_BITS + MAX_OFFSET_WIDTH,
	localparam int NB_W  = $clog2(HB + 1),
	localparam int ENT_W = HB + NB_W + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   kind,
	input  wire logic [OFFSET_BITS-1:0] rel_offset,
	input  wire logic [BOFF_BITS-1:0]   bit_pos,
	input  wire logic [BLEN_BITS-1:0]   bit_length,
	input  wire logic [DATA_BITS-1:0]   data_byte,
	output logic                        push_valid,
	input  wire logic                   push_ready,
	output logic [ENT_W-1:0]            push_entry
);

	localparam int EXT_W = (MAX_OFFSET_WIDTH > OFFSET_BITS) ? MAX_OFFSET_WIDTH : OFFSET_BITS;

	logic                        open_q;
	logic [BLEN_BITS-1:0]        left_q;

	logic                        s1_valid_q;
	logic                        s1_hdr_q;
	logic [W_FIELD_BITS-1:0]     s1_w_q;
	logic [MAX_OFFSET_WIDTH-1:0] s1_off_q;
	logic [TAIL_BITS-1:0]        s1_tail_q;
	logic [DATA_BITS-1:0]        s1_data_q;
	logic [3:0]                  s1_n_q;
	logic                        s1_close_q;

	logic                        accept;
	logic                        is_hdr;
	logic                        keep;
	logic [W_FIELD_BITS-1:0]     w_raw;
	logic                        sat;
	logic [W_FIELD_BITS-1:0]     w_sat;
	logic [EXT_W-1:0]            off_ext;
	logic [MAX_OFFSET_WIDTH-1:0] off_sat;
	logic [3:0]                  n;
	logic [DATA_BITS-1:0]        data_la;
	logic [BLEN_BITS-1:0]        left_next;

	logic [W_FIELD_BITS-1:0]           sh;
	logic [MAX_OFFSET_WIDTH+TAIL_BITS-1:0] lfield;
	logic [HB-1:0]                     ent_bits;
	logic [NB_W-1:0]                   ent_n;

	assign accept = in_valid && in_ready;
	assign is_hdr = (kind == KIND_HEADER);
	assign keep   = is_hdr ? !open_q : open_q;

	always_comb begin
		w_raw = W_FIELD_BITS'(1);
		for (int i = 1; i < OFFSET_BITS; i++) begin
			if (rel_offset[i]) begin
				w_raw = W_FIELD_BITS'(i + 1);
			end
		end
	end

	assign sat     = (w_raw > W_FIELD_BITS'(MAX_OFFSET_WIDTH));
	assign w_sat   = sat ? W_FIELD_BITS'(MAX_OFFSET_WIDTH) : w_raw;
	assign off_ext = EXT_W'(rel_offset);
	assign off_sat = sat ? {MAX_OFFSET_WIDTH{1'b1}} : off_ext[MAX_OFFSET_WIDTH-1:0];

	assign n         = (left_q < BLEN_BITS'(DATA_BITS)) ? left_q[3:0] : 4'(DATA_BITS);
	assign data_la   = DATA_BITS'(data_byte << (4'(DATA_BITS) - n));
	assign left_next = left_q - BLEN_BITS'(n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			left_q     <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept && keep) begin
				if (is_hdr) begin
					open_q <= (bit_length != '0);
					left_q <= bit_length;
				end else begin
					open_q <= (left_next != '0);
					left_q <= left_next;
				end
			end
			if (in_ready) begin
				s1_valid_q <= accept && keep;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_hdr_q  <= is_hdr;
			s1_w_q    <= w_sat;
			s1_off_q  <= off_sat;
			s1_tail_q <= {bit_pos, bit_length};
			s1_data_q <= data_la;
			s1_n_q    <= n;
			s1_close_q <= is_hdr ? (bit_length == '0) : (left_next == '0);
		end
	end

	assign sh     = W_FIELD_BITS'(MAX_OFFSET_WIDTH) - s1_w_q;
	assign lfield = {s1_off_q, s1_tail_q} << sh;

	always_comb begin
		if (s1_hdr_q) begin
			ent_bits = {s1_w_q, lfield};
			ent_n    = NB_W'(HDR_FIXED_BITS) + NB_W'(s1_w_q);
		end else begin
			ent_bits = {s1_data_q, {(HB - DATA_BITS){1'b0}}};
			ent_n    = NB_W'(s1_n_q);
		end
	end

	assign push_valid = s1_valid_q;
	assign push_entry = {s1_close_q, ent_n, ent_bits};
	assign in_ready   = !s1_valid_q || push_ready;

	a_closed_no_left: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (left_q == '0))
		else $error("closed record still expects data bits");

	a_data_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_hdr_q) |-> (s1_n_q != '0))
		else $error("empty data run queued");

endmodule

`default_nettype wire

FILE: rtl/krbp_fifo.sv
// Short entry queue between the front end and the back end.
`default_nettype none

module krbp_fifo
	import krbp_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic [WIDTH-1:0]      rd_data
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (count_q != CNT_W'(FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/krbp_back.sv
// Back end: merges bit runs into the accumulator and emits packed bytes.
`default_nettype none

module krbp_back
	import krbp_pkg::*;
#(
	parameter int MAX_OFFSET_WIDTH = KRBP_MAX_OFFSET_WIDTH,
	localparam int HB    = HDR_FIXED_BITS + MAX_OFFSET_WIDTH,
	localparam int NB_W  = $clog2(HB + 1),
	localparam int ENT_W = HB + NB_W + 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             e_valid,
	output logic                  e_ready,
	input  wire logic [ENT_W-1:0] e_entry,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [DATA_BITS-1:0]  out_byte,
	output logic                  out_last
);

	localparam int ACC_W  = HB + DATA_BITS - 1;
	localparam int HELD_W = $clog2(ACC_W + 1);

	logic [ACC_W-1:0]     acc_q;
	logic [HELD_W-1:0]    held_q;
	logic                 close_q;
	logic                 out_valid_q;
	logic [DATA_BITS-1:0] out_byte_q;
	logic                 out_last_q;

	logic [HB-1:0]        e_bits;
	logic [NB_W-1:0]      e_n;
	logic                 e_close;
	logic                 out_free;
	logic                 emit;
	logic                 last_byte;
	logic [ACC_W-1:0]     acc_e;
	logic [HELD_W-1:0]    held_e;
	logic                 close_e;
	logic                 pop;

	assign {e_close, e_n, e_bits} = e_entry;

	assign out_free  = !out_valid_q || out_ready;
	assign emit      = out_free && ((held_q >= HELD_W'(DATA_BITS)) || (close_q && held_q != '0));
	assign last_byte = close_q && (held_q <= HELD_W'(DATA_BITS));

	always_comb begin
		if (emit) begin
			acc_e   = acc_q << DATA_BITS;
			held_e  = (held_q >= HELD_W'(DATA_BITS)) ? held_q - HELD_W'(DATA_BITS) : '0;
			close_e = close_q && !last_byte;
		end else begin
			acc_e   = acc_q;
			held_e  = held_q;
			close_e = close_q;
		end
	end

	assign pop     = e_valid && (held_e < HELD_W'(DATA_BITS)) && !close_e;
	assign e_ready = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			close_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				held_q  <= held_e + HELD_W'(e_n);
				close_q <= e_close;
			end else begin
				held_q  <= held_e;
				close_q <= close_e;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (pop) begin
			acc_q <= acc_e | ({e_bits, {(DATA_BITS - 1){1'b0}}} >> held_e);
		end else begin
			acc_q <= acc_e;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= acc_q[ACC_W-1 -: DATA_BITS];
			out_last_q <= last_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	a_close_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		close_q |-> (held_q != '0))
		else $error("record close pending with no bits held");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_byte && !pop) |=> (held_q == '0 && !close_q))
		else $error("accumulator not empty after final byte");

endmodule

`default_nettype wire

FILE: rtl/key_record_bit_packer_top.sv
// Top level of the key record bit packer.
// Path: front-end stage, entry queue, accumulator, then the output register that holds each byte.
// Rates: a request per cycle while the queue has room, a byte per cycle while m_tready is high.
// A header adds 17 + w bits to the packed stream; a data request adds at most eight.
// A request is taken while bytes wait: the entry queue and output register split front and back.
// Reset: arst_n clears the open record, the queue and the accumulator asynchronously.
`default_nettype none

module key_record_bit_packer_top
	import krbp_pkg::*;
#(
	parameter int MAX_OFFSET_WIDTH = KRBP_MAX_OFFSET_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [TDATA_BITS-1:0] s_tdata,  // rel_offset, bit_pos, bit_length, data_byte
	input  wire logic                  s_tuser,  // kind
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [DATA_BITS-1:0]       m_tdata,  // packed_byte
	output logic                       m_tlast   // last
);

	localparam int HB    = HDR_FIXED_BITS + MAX_OFFSET_WIDTH;
	localparam int NB_W  = $clog2(HB + 1);
	localparam int ENT_W = HB + NB_W + 1;

	logic             push_valid;
	logic             push_ready;
	logic [ENT_W-1:0] push_entry;
	logic             pop_valid;
	logic             pop_ready;
	logic [ENT_W-1:0] pop_entry;

	krbp_front #(
		.MAX_OFFSET_WIDTH(MAX_OFFSET_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.kind       (s_tuser),
		.rel_offset (s_tdata[OFFSET_LSB +: OFFSET_BITS]),
		.bit_pos    (s_tdata[BOFF_LSB +: BOFF_BITS]),
		.bit_length (s_tdata[BLEN_LSB +: BLEN_BITS]),
		.data_byte  (s_tdata[DATA_LSB +: DATA_BITS]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	krbp_fifo #(
		.WIDTH(ENT_W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_data (push_entry),
		.rd_valid(pop_valid),
		.rd_ready(pop_ready),
		.rd_data (pop_entry)
	);

	krbp_back #(
		.MAX_OFFSET_WIDTH(MAX_OFFSET_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.e_valid  (pop_valid),
		.e_ready  (pop_ready),
		.e_entry  (pop_entry),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte (m_tdata),
		.out_last (m_tlast)
	);

endmodule

`default_nettype wire
